/* hw/rtl/ang_pkg.sv */
// ----------------------------------------------------------------------------
// ang_pkg: shared types and constants of the adaptive noise gate
// Holds the default parameter values, field widths, register indexes,
// sequencer states and the structs passed between the gate's modules.
// ----------------------------------------------------------------------------
package ang_pkg;

	// Default values of the top level parameters.
	localparam int FLOOR_WINDOW_DEF      = 100;
	localparam int GROUP_FRAMES_DEF      = 5;
	localparam int STATS_WINDOW_DEF      = 400;
	localparam int MAX_FRAME_SAMPLES_DEF = 4096;

	// Field widths.
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SUM_W    = 28;
	localparam int COUNT_W  = 13;
	localparam int LOUD_W   = 24;
	localparam int GAIN_W   = 4;
	localparam int DELAY_W  = 4;
	localparam int PROD_W   = LOUD_W + GAIN_W;

	// Shared divider widths: dividend holds sum * 256, divisor the sample count.
	localparam int DIV_N_W = SUM_W + 8;
	localparam int DIV_D_W = COUNT_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Result packing: gate_open, clipped, then four 24-bit levels.
	localparam int OUT_BITS   = 2 + 4 * LOUD_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Register reset values.
	localparam logic [MAG_W-1:0]   CLIP_LEVEL_RST  = 16'd29491;
	localparam logic [GAIN_W-1:0]  GATE_HEIGHT_RST = 4'd7;
	localparam logic [COUNT_W-1:0] OPEN_COUNT_RST  = 13'd5;
	localparam logic [DELAY_W-1:0] CLOSE_DELAY_RST = 4'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LEVEL  = 8'd0,
		REG_GATE_HEIGHT = 8'd1,
		REG_OPEN_COUNT  = 8'd2,
		REG_CLOSE_DELAY = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LGO,
		ST_LDIV,
		ST_UPDATE,
		ST_FDIV,
		ST_OUT
	} ang_state_t;

	// Running totals of the frame in progress.
	typedef struct packed {
		logic [SUM_W-1:0]   abs_sum;
		logic [COUNT_W-1:0] samples_seen;
		logic [COUNT_W-1:0] over_count;
		logic               clip_seen;
	} frame_acc_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

/* hw/rtl/ang_divider.sv */
// ----------------------------------------------------------------------------
// ang_divider: shared restoring divider
// Produces one quotient bit per cycle. A start pulse loads the operands;
// done pulses for one cycle once the quotient is ready and stays valid.
// ----------------------------------------------------------------------------
module ang_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ang_pkg::DIV_N_W-1:0] dividend,
	input  logic [ang_pkg::DIV_D_W-1:0] divisor,
	output logic [ang_pkg::DIV_N_W-1:0] quotient,
	output ang_pkg::div_status_t        status
);

	localparam int N_W   = ang_pkg::DIV_N_W;
	localparam int D_W   = ang_pkg::DIV_D_W;
	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[N_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

/* hw/rtl/ang_frame_acc.sv */
// ----------------------------------------------------------------------------
// ang_frame_acc: per-sample frame accumulator
// Takes the magnitude of each sample, sums it, counts samples and the ones
// above the gate threshold, and flags clipping. Flags the frame's end.
// ----------------------------------------------------------------------------
module ang_frame_acc #(
	parameter int MAX_FRAME_SAMPLES = ang_pkg::MAX_FRAME_SAMPLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         clear,
	input  logic [ang_pkg::SAMPLE_W-1:0] sample,
	input  logic                         last,
	input  logic [ang_pkg::MAG_W-1:0]    clip_level,
	input  logic [ang_pkg::GAIN_W-1:0]   gate_height,
	input  logic [ang_pkg::LOUD_W-1:0]   floor_level,
	output logic                         frame_end,
	output ang_pkg::frame_acc_t          acc
);

	localparam int COUNT_W = ang_pkg::COUNT_W;
	localparam int PROD_W  = ang_pkg::PROD_W;
	// The magnitude of the most negative sample needs one bit more than a sample.
	localparam int ABS_W   = ang_pkg::MAG_W + 1;

	ang_pkg::frame_acc_t     acc_q;
	logic signed [16:0]      sample_x;
	logic [ABS_W-1:0]        mag;
	logic [PROD_W-1:0]       thresh;
	logic [PROD_W-1:0]       mag_scaled;
	logic                    over;
	logic [COUNT_W-1:0]      seen_next;

	// Magnitude, threshold test and frame end of the current sample.
	always_comb begin
		sample_x   = {sample[ang_pkg::SAMPLE_W-1], sample};
		mag        = sample[ang_pkg::SAMPLE_W-1] ? ABS_W'(-sample_x)
			: ABS_W'(sample_x);
		thresh     = PROD_W'(floor_level) * PROD_W'(gate_height);
		mag_scaled = PROD_W'({mag, 8'h00});
		over       = mag_scaled > thresh;
		seen_next  = acc_q.samples_seen + 1'b1;
		frame_end  = last || (seen_next >= COUNT_W'(MAX_FRAME_SAMPLES));
	end

	// Running totals, cleared once the frame's result has been issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (take) begin
			acc_q.abs_sum      <= acc_q.abs_sum + ang_pkg::SUM_W'(mag);
			acc_q.samples_seen <= seen_next;
			if (mag >= {1'b0, clip_level}) begin
				acc_q.clip_seen <= 1'b1;
			end
			if (over && (acc_q.over_count != '1)) begin
				acc_q.over_count <= acc_q.over_count + 1'b1;
			end
		end
	end

	assign acc = acc_q;

endmodule

/* hw/rtl/adaptive_noise_gate.sv */
// ----------------------------------------------------------------------------
// adaptive_noise_gate: audio noise gate with noise floor tracking
// Gates a stream of signed 16-bit samples against a measured noise floor
// and reports per-frame loudness statistics.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one sample per transfer, s_tlast marking the last
//   sample of a frame. A frame also ends on its MAX_FRAME_SAMPLES-th sample.
//   A sample that does not end a frame leaves s_tready high. A frame end
//   yields one result on the m_ channel once the shared divider, taking one
//   quotient bit per cycle, has formed the frame mean; the frame that fills
//   the loudness window runs the divider a second time for the floor mean.
//   s_tready is low while a frame end is being worked on. The result is held
//   in an output register; the next frame's samples are taken while it waits,
//   and a following frame end waits only for it to be taken when m_tready is
//   low. Registers are written on the cfg_ channel (always ready) while idle;
//   the user must keep to this, as the block itself does not enforce it.
//   Reset clears all statistics but the frame mean and smallest group sum,
//   closes the gate and loads the register defaults; s_tready is high then.
// ----------------------------------------------------------------------------
module adaptive_noise_gate #(
	parameter int FLOOR_WINDOW      = ang_pkg::FLOOR_WINDOW_DEF,
	parameter int GROUP_FRAMES      = ang_pkg::GROUP_FRAMES_DEF,
	parameter int STATS_WINDOW      = ang_pkg::STATS_WINDOW_DEF,
	parameter int MAX_FRAME_SAMPLES = ang_pkg::MAX_FRAME_SAMPLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Sample channel.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [15:0] sample
	input  logic                           s_tlast,   // last_in_frame
	// Result channel.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] gate_open, [1] clipped, [25:2] loudness, [49:26] noise_floor,
	// [73:50] quietest, [97:74] loudest, [103:98] zero
	output logic [ang_pkg::OUT_DATA_W-1:0] m_tdata,
	// Configuration channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ang_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ang_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int LOUD_W   = ang_pkg::LOUD_W;
	localparam int RING_W   = $clog2(FLOOR_WINDOW);
	localparam int GRP_W    = $clog2(GROUP_FRAMES + 1);
	localparam int GSUM_W   = LOUD_W + GRP_W;
	localparam int STAT_W   = $clog2(STATS_WINDOW + 2);
	localparam int N_W      = ang_pkg::DIV_N_W;
	localparam int D_W      = ang_pkg::DIV_D_W;

	// Configuration registers.
	logic [ang_pkg::MAG_W-1:0]   clip_level_q;
	logic [ang_pkg::GAIN_W-1:0]  gate_height_q;
	logic [ang_pkg::COUNT_W-1:0] open_count_q;
	logic [ang_pkg::DELAY_W-1:0] close_delay_q;

	// Sequencer and frame statistics.
	ang_pkg::ang_state_t         state_q;
	ang_pkg::ang_state_t         state_d;
	logic [LOUD_W-1:0]           loud_q;
	logic [LOUD_W-1:0]           floor_q;
	logic [LOUD_W-1:0]           quiet_q;
	logic [LOUD_W-1:0]           loudest_q;
	logic [STAT_W-1:0]           stats_cnt_q;
	logic [RING_W-1:0]           ring_idx_q;
	logic [GRP_W-1:0]            grp_cnt_q;
	logic [GSUM_W-1:0]           gsum_q;
	logic [GSUM_W-1:0]           min_q;
	logic                        found_q;
	logic                        open_q;
	logic [ang_pkg::DELAY_W-1:0] close_cd_q;
	logic                        m_tvalid_q;
	logic [ang_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// Control signals.
	logic                        s_take;
	logic                        frame_end;
	logic                        acc_clear;
	logic                        out_load;
	logic                        div_start;
	logic [N_W-1:0]              div_dividend;
	logic [D_W-1:0]              div_divisor;
	logic [N_W-1:0]              div_quotient;
	ang_pkg::div_status_t        div_st;
	ang_pkg::frame_acc_t         acc;

	// Frame end update terms.
	logic [LOUD_W-1:0]           quiet_min;
	logic [LOUD_W-1:0]           loud_max;
	logic                        stats_wrap;
	logic                        ring_last;
	logic                        grp_last;
	logic [GSUM_W-1:0]           gsum_next;
	logic                        cand_better;
	logic                        found_new;
	logic [GSUM_W-1:0]           min_new;
	logic [ang_pkg::DELAY_W-1:0] close_cd_dec;
	logic                        gate_hit;

	// Per-sample accumulation.
	ang_frame_acc #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (s_take),
		.clear      (acc_clear),
		.sample     (s_tdata),
		.last       (s_tlast),
		.clip_level (clip_level_q),
		.gate_height(gate_height_q),
		.floor_level(floor_q),
		.frame_end  (frame_end),
		.acc        (acc)
	);

	// Shared divider for the frame mean and the floor mean.
	ang_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quotient),
		.status  (div_st)
	);

	// Configuration writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_level_q  <= ang_pkg::CLIP_LEVEL_RST;
			gate_height_q <= ang_pkg::GATE_HEIGHT_RST;
			open_count_q  <= ang_pkg::OPEN_COUNT_RST;
			close_delay_q <= ang_pkg::CLOSE_DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ang_pkg::REG_CLIP_LEVEL:  clip_level_q  <= cfg_data[ang_pkg::MAG_W-1:0];
				ang_pkg::REG_GATE_HEIGHT: gate_height_q <= cfg_data[ang_pkg::GAIN_W-1:0];
				ang_pkg::REG_OPEN_COUNT:  open_count_q  <= cfg_data[ang_pkg::COUNT_W-1:0];
				ang_pkg::REG_CLOSE_DELAY: close_delay_q <= cfg_data[ang_pkg::DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Statistics, floor group and gate terms for the frame end.
	always_comb begin
		quiet_min    = (quiet_q > loud_q) ? loud_q : quiet_q;
		loud_max     = (loudest_q < loud_q) ? loud_q : loudest_q;
		stats_wrap   = stats_cnt_q > STAT_W'(STATS_WINDOW);
		ring_last    = ring_idx_q == RING_W'(FLOOR_WINDOW - 1);
		grp_last     = grp_cnt_q == GRP_W'(GROUP_FRAMES - 1);
		gsum_next    = gsum_q + GSUM_W'(loud_q);
		cand_better  = !found_q || (gsum_next < min_q);
		found_new    = found_q || grp_last;
		min_new      = (grp_last && cand_better) ? gsum_next : min_q;
		close_cd_dec = (close_cd_q != '0) ? close_cd_q - 1'b1 : close_cd_q;
		gate_hit     = acc.over_count > open_count_q;
	end

	// Sequencer: next state and control strobes.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = {acc.abs_sum, 8'h00};
		div_divisor  = acc.samples_seen;
		acc_clear    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ang_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && frame_end) begin
					state_d = ang_pkg::ST_LGO;
				end
			end
			ang_pkg::ST_LGO: begin
				div_start = 1'b1;
				state_d   = ang_pkg::ST_LDIV;
			end
			ang_pkg::ST_LDIV: begin
				if (div_st.done) begin
					state_d = ang_pkg::ST_UPDATE;
				end
			end
			ang_pkg::ST_UPDATE: begin
				div_dividend = N_W'(min_new);
				div_divisor  = D_W'(GROUP_FRAMES);
				if (ring_last && found_new) begin
					div_start = 1'b1;
					state_d   = ang_pkg::ST_FDIV;
				end else begin
					state_d = ang_pkg::ST_OUT;
				end
			end
			ang_pkg::ST_FDIV: begin
				if (div_st.done) begin
					state_d = ang_pkg::ST_OUT;
				end
			end
			ang_pkg::ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load  = 1'b1;
					acc_clear = 1'b1;
					state_d   = ang_pkg::ST_IDLE;
				end
			end
			default: state_d = ang_pkg::ST_IDLE;
		endcase
	end

	assign s_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ang_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame mean and floor mean capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= '0;
		end else if ((state_q == ang_pkg::ST_FDIV) && div_st.done) begin
			floor_q <= div_quotient[LOUD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ang_pkg::ST_LDIV) && div_st.done) begin
			loud_q <= div_quotient[LOUD_W-1:0];
		end
	end

	// Frame end update of statistics, floor groups and gate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q     <= '1;
			loudest_q   <= '0;
			stats_cnt_q <= '0;
			ring_idx_q  <= '0;
			grp_cnt_q   <= '0;
			gsum_q      <= '0;
			found_q     <= 1'b0;
			open_q      <= 1'b0;
			close_cd_q  <= '0;
		end else if (state_q == ang_pkg::ST_UPDATE) begin
			if (stats_wrap) begin
				quiet_q     <= '1;
				loudest_q   <= '0;
				stats_cnt_q <= '0;
			end else begin
				quiet_q     <= quiet_min;
				loudest_q   <= loud_max;
				stats_cnt_q <= stats_cnt_q + 1'b1;
			end

			if (ring_last) begin
				ring_idx_q <= '0;
				grp_cnt_q  <= '0;
				gsum_q     <= '0;
				found_q    <= 1'b0;
			end else begin
				ring_idx_q <= ring_idx_q + 1'b1;
				found_q    <= found_new;
				if (grp_last) begin
					grp_cnt_q <= '0;
					gsum_q    <= '0;
				end else begin
					grp_cnt_q <= grp_cnt_q + 1'b1;
					gsum_q    <= gsum_next;
				end
			end

			if (gate_hit) begin
				open_q     <= 1'b1;
				close_cd_q <= close_delay_q;
			end else begin
				close_cd_q <= close_cd_dec;
				if (close_cd_dec == '0) begin
					open_q <= 1'b0;
				end
			end
		end
	end

	// Smallest group sum of the current window pass.
	always_ff @(posedge clk) begin
		if (state_q == ang_pkg::ST_UPDATE) begin
			min_q <= min_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= ang_pkg::OUT_DATA_W'({loudest_q, quiet_q, floor_q, loud_q,
				acc.clip_seen, open_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The divider is only started when it is free.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	// A divider result only arrives while the sequencer waits for one.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ang_pkg::ST_LDIV || state_q == ang_pkg::ST_FDIV))
		else $error("divider result outside a wait state");

	// A result is loaded only from the output state.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ang_pkg::ST_OUT))
		else $error("result raised outside the output state");

	// A closed gate has no countdown left.
	a_closed_cd: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (close_cd_q == '0))
		else $error("countdown running while the gate is closed");

	// No samples are taken while a frame end is in progress.
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ang_pkg::ST_IDLE) |-> !s_take)
		else $error("sample taken during frame end work");

endmodule

/* tb/adaptive_noise_gate_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_noise_gate_test: self-checking testbench of the adaptive noise gate
// Streams audio frames into the gate, with idle cycles on both sides and
// register changes between phases. A frame-level predictor works out every
// result from the accepted samples, and each result transfer is compared
// with it field by field.
// ----------------------------------------------------------------------------
module adaptive_noise_gate_test;
	import ang_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int SETTLE_CYCLES   = 100;
	localparam int STALL_LIMIT     = 2000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 190;

	// Amplitude class of a random frame.
	typedef enum int unsigned {
		LVL_QUIET,
		LVL_MEDIUM,
		LVL_FULL,
		LVL_EXTREME
	} level_kind_t;

	// Frame-level predictor of the gate, with a queue of the results it owes.
	class noise_gate_model;
		typedef struct packed {
			logic [LOUD_W-1:0] loudest;
			logic [LOUD_W-1:0] quietest;
			logic [LOUD_W-1:0] noise_floor;
			logic [LOUD_W-1:0] loudness;
			logic              clipped;
			logic              gate_open;
		} frame_result_t;

		logic [MAG_W-1:0]   clip_level;
		logic [GAIN_W-1:0]  gate_height;
		logic [COUNT_W-1:0] open_count;
		logic [DELAY_W-1:0] close_delay;

		logic [SUM_W-1:0]   abs_sum;
		logic [COUNT_W-1:0] samples_seen;
		logic [COUNT_W-1:0] over_count;
		logic               clip_seen;
		logic [LOUD_W-1:0]  floor_level;
		logic [LOUD_W-1:0]  quietest_level;
		logic [LOUD_W-1:0]  loudest_level;
		logic [8:0]         stats_frames;
		logic [LOUD_W-1:0]  loudness_ring [FLOOR_WINDOW_DEF];
		int unsigned        ring_pos;
		logic               open_flag;
		logic [DELAY_W-1:0] close_countdown;

		frame_result_t      expected_frames [$];
		int unsigned        errors;
		int unsigned        frames_checked;

		function new();
			clip_level      = CLIP_LEVEL_RST;
			gate_height     = GATE_HEIGHT_RST;
			open_count      = OPEN_COUNT_RST;
			close_delay     = CLOSE_DELAY_RST;
			abs_sum         = '0;
			samples_seen    = '0;
			over_count      = '0;
			clip_seen       = 1'b0;
			floor_level     = '0;
			quietest_level  = '1;
			loudest_level   = '0;
			stats_frames    = '0;
			ring_pos        = 0;
			open_flag       = 1'b0;
			close_countdown = '0;
			errors          = 0;
			frames_checked  = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CLIP_LEVEL:  clip_level  = val[MAG_W-1:0];
				REG_GATE_HEIGHT: gate_height = val[GAIN_W-1:0];
				REG_OPEN_COUNT:  open_count  = val[COUNT_W-1:0];
				REG_CLOSE_DELAY: close_delay = val[DELAY_W-1:0];
				default: ;
			endcase
		endfunction

		// The floor becomes the smallest mean over the whole groups of the ring.
		function void refresh_floor();
			logic [31:0] group_sum;
			logic [31:0] group_mean;
			logic [31:0] best;
			bit          found;
			found = 1'b0;
			best  = '0;
			for (int first = 0; first + GROUP_FRAMES_DEF <= FLOOR_WINDOW_DEF;
					first += GROUP_FRAMES_DEF) begin
				group_sum = '0;
				for (int k = 0; k < GROUP_FRAMES_DEF; k++)
					group_sum += loudness_ring[first + k];
				group_mean = group_sum / GROUP_FRAMES_DEF;
				if (!found || group_mean < best) begin
					best  = group_mean;
					found = 1'b1;
				end
			end
			if (found)
				floor_level = best[LOUD_W-1:0];
		endfunction

		// Accounts for one accepted sample; a frame end queues its result.
		function void note_sample(logic [SAMPLE_W-1:0] smp, logic last);
			logic [MAG_W:0]    mag;
			logic [PROD_W-1:0] limit;
			logic [LOUD_W-1:0] loud;
			frame_result_t     res;
			mag = smp[SAMPLE_W-1] ? ({1'b1, 16'h0000} - {1'b0, smp}) : {1'b0, smp};
			if (mag >= {1'b0, clip_level})
				clip_seen = 1'b1;
			abs_sum += mag;
			samples_seen++;
			limit = floor_level * gate_height;
			if ({mag, 8'h00} > limit && over_count != '1)
				over_count++;
			if (!last && samples_seen < MAX_FRAME_SAMPLES_DEF)
				return;

			loud = LOUD_W'({abs_sum, 8'h00} / samples_seen);

			// Running extremes, cleared once the statistics window has passed.
			if (quietest_level > loud)
				quietest_level = loud;
			if (loudest_level < loud)
				loudest_level = loud;
			if (stats_frames > STATS_WINDOW_DEF) begin
				quietest_level = '1;
				loudest_level  = '0;
				stats_frames   = '0;
			end else begin
				stats_frames++;
			end

			// Loudness history; a full ring yields a new floor.
			if (ring_pos >= FLOOR_WINDOW_DEF)
				ring_pos = 0;
			loudness_ring[ring_pos] = loud;
			ring_pos++;
			if (ring_pos >= FLOOR_WINDOW_DEF) begin
				refresh_floor();
				ring_pos = 0;
			end

			// Gate: open on a busy frame, close after the quiet countdown runs out.
			if (over_count > open_count) begin
				open_flag       = 1'b1;
				close_countdown = close_delay;
			end else begin
				if (close_countdown != 0)
					close_countdown--;
				if (close_countdown == 0)
					open_flag = 1'b0;
			end

			res.gate_open   = open_flag;
			res.clipped     = clip_seen;
			res.loudness    = loud;
			res.noise_floor = floor_level;
			res.quietest    = quietest_level;
			res.loudest     = loudest_level;
			expected_frames.push_back(res);

			abs_sum      = '0;
			samples_seen = '0;
			over_count   = '0;
			clip_seen    = 1'b0;
		endfunction

		task report(string msg);
			$display("ERROR at %0t ns, result %0d: %s", $time, frames_checked, msg);
			errors++;
		endtask

		task compare_field(string name, logic [LOUD_W-1:0] got, logic [LOUD_W-1:0] want);
			if (got !== want)
				report($sformatf("%s is 0x%06h, expected 0x%06h", name, got, want));
		endtask

		// Compares one result transfer with the oldest pending frame result.
		task check_frame(logic [OUT_DATA_W-1:0] word);
			frame_result_t got;
			frame_result_t want;
			got = word[OUT_BITS-1:0];
			frames_checked++;
			if (expected_frames.size() == 0) begin
				report("result arrived with no frame end pending");
				return;
			end
			want = expected_frames.pop_front();
			compare_field("gate_open", LOUD_W'(got.gate_open), LOUD_W'(want.gate_open));
			compare_field("clipped", LOUD_W'(got.clipped), LOUD_W'(want.clipped));
			compare_field("loudness", got.loudness, want.loudness);
			compare_field("noise_floor", got.noise_floor, want.noise_floor);
			compare_field("quietest", got.quietest, want.quietest);
			compare_field("loudest", got.loudest, want.loudest);
			if (word[OUT_DATA_W-1:OUT_BITS] !== '0)
				report("padding bits of the result are not zero");
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b1;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	noise_gate_model gate_model;
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_idle_pct = 0;
	int unsigned     items_sent    = 0;
	int unsigned     stall_cycles  = 0;

	adaptive_noise_gate u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result side: check each transfer, then decide whether to stall next cycle.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			gate_model.check_frame(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Sends one sample, after a random number of idle cycles.
	task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		gate_model.note_sample(smp, last);
		items_sent++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		gate_model.write_reg(idx, val);
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] clip, input logic [CFG_DATA_W-1:0] height,
			input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] delay);
		write_reg(REG_CLIP_LEVEL, clip);
		write_reg(REG_GATE_HEIGHT, height);
		write_reg(REG_OPEN_COUNT, count);
		write_reg(REG_CLOSE_DELAY, delay);
		cfg_valid <= 1'b0;
	endtask

	// Stops sending and waits until every frame result has been taken.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (gate_model.expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A sample of the given class; now and then one right at the gate threshold.
	function automatic logic [SAMPLE_W-1:0] pick_sample(level_kind_t kind);
		logic [PROD_W-1:0] bound_mag;
		logic [MAG_W:0]    mag;
		bound_mag = (gate_model.floor_level * gate_model.gate_height) >> 8;
		if ($urandom_range(99) < 5 && bound_mag < 32768) begin
			mag = bound_mag[MAG_W:0] + (MAG_W + 1)'($urandom_range(1));
		end else begin
			case (kind)
				LVL_QUIET:  mag = (MAG_W + 1)'($urandom_range(64));
				LVL_MEDIUM: mag = (MAG_W + 1)'($urandom_range(4000));
				LVL_FULL:   return SAMPLE_W'($urandom());
				default: begin
					case ($urandom_range(3))
						0:       mag = 17'd32768;
						1:       mag = 17'd32767;
						2:       mag = {1'b0, gate_model.clip_level};
						default: mag = {1'b0, gate_model.clip_level} - 1'b1;
					endcase
				end
			endcase
		end
		if ($urandom_range(1))
			mag = -mag;
		return mag[SAMPLE_W-1:0];
	endfunction

	// Mostly very short frames, so that the ring and the statistics window turn over.
	task automatic send_random_frame();
		int unsigned len;
		int unsigned roll;
		level_kind_t kind;
		roll = $urandom_range(99);
		if (roll < 80)
			len = $urandom_range(2, 1);
		else if (roll < 97)
			len = $urandom_range(6, 3);
		else
			len = $urandom_range(24, 7);
		roll = $urandom_range(99);
		kind = (roll < 40) ? LVL_QUIET : (roll < 65) ? LVL_MEDIUM :
			(roll < 95) ? LVL_FULL : LVL_EXTREME;
		for (int unsigned i = 1; i <= len; i++)
			push_sample(pick_sample(kind), i == len);
	endtask

	initial begin
		int unsigned target;
		arst_n <= 1'b0;
		gate_model = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 75;

		// Full-scale extremes in one frame, clipped under the default level.
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h0000, 1'b1);
		// Single-sample frames: silence, then the negative sample of smallest magnitude.
		push_sample(16'h0000, 1'b1);
		push_sample(16'hFFFF, 1'b1);
		// A busy frame opens the gate; five silent frames close it again.
		repeat (6) push_sample(16'd1000, 1'b0);
		push_sample(16'd1000, 1'b1);
		repeat (5) push_sample(16'h0000, 1'b1);
		// Samples exactly at and just under the clip level, and a negative one at it.
		push_sample(16'd29491, 1'b1);
		push_sample(16'd29490, 1'b1);
		push_sample(16'h8CCD, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			if (phase == 2) begin
				send_idle_pct = 75;
				recv_idle_pct = 24;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
				0: set_regs(16'd32768, 16'd15, 16'd0, 16'd15);
				1: set_regs(16'd0, 16'd1, 16'd1, 16'd1);
				2: set_regs(CFG_DATA_W'($urandom_range(65535)), 16'd0, 16'd2, 16'd0);
				3: set_regs(16'hFFFF, CFG_DATA_W'($urandom_range(15, 1)), 16'd8191,
					CFG_DATA_W'($urandom_range(15)));
				4: set_regs(CFG_DATA_W'($urandom_range(32768)), 16'd7, 16'd0, 16'd5);
				default: set_regs(16'd1, CFG_DATA_W'($urandom_range(15, 1)),
					CFG_DATA_W'($urandom_range(3)), 16'd8);
			endcase
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target)
				send_random_frame();
		end

		wait_drained();
		if (gate_model.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
